// ----- sv/isod_pkg.sv -----
`default_nettype none

package isod_pkg;

  localparam logic [7:0] SEP_CHAR = 8'h2D;
  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;

  localparam logic [3:0] POS_Y0  = 4'd0;
  localparam logic [3:0] POS_Y1  = 4'd1;
  localparam logic [3:0] POS_Y2  = 4'd2;
  localparam logic [3:0] POS_Y3  = 4'd3;
  localparam logic [3:0] POS_S1  = 4'd4;
  localparam logic [3:0] POS_M0  = 4'd5;
  localparam logic [3:0] POS_M1  = 4'd6;
  localparam logic [3:0] POS_S2  = 4'd7;
  localparam logic [3:0] POS_D0  = 4'd8;
  localparam logic [3:0] POS_D1  = 4'd9;
  localparam logic [3:0] POS_SAT = 4'd11;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_FMT   = 3'd1;
  localparam logic [2:0] ST_YEAR  = 3'd2;
  localparam logic [2:0] ST_MONTH = 3'd3;
  localparam logic [2:0] ST_DAY   = 3'd4;
  localparam logic [2:0] ST_CAL   = 3'd5;

  localparam int FLD_YEAR  = 0;
  localparam int FLD_MONTH = 1;
  localparam int FLD_DAY   = 2;

  // 365 * 1970 plus leap days counted from year -1200 up to 1969
  localparam logic [23:0] YEAR_BIAS = 24'd719819;

  typedef struct packed {
    logic [3:0]  idx;
    logic        fmt_bad;
    logic [2:0]  bad;
    logic [2:0]  sign;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [22:0] year_base;
    logic        leap;
  } parse_t;

  typedef struct packed {
    logic [22:0] days;
    logic [2:0]  status;
  } result_t;

  function automatic logic [6:0] acc10(input logic [6:0] acc, input logic [3:0] dig);
    logic [9:0] t;
    t = 10'(acc) * 10'd10 + 10'(dig);
    return t[6:0];
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:                   n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                n = 5'd31;
    endcase
    return n;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
    logic [8:0] n;
    case (m)
      4'd1:    n = 9'd0;
      4'd2:    n = 9'd31;
      4'd3:    n = 9'd59;
      4'd4:    n = 9'd90;
      4'd5:    n = 9'd120;
      4'd6:    n = 9'd151;
      4'd7:    n = 9'd181;
      4'd8:    n = 9'd212;
      4'd9:    n = 9'd243;
      4'd10:   n = 9'd273;
      4'd11:   n = 9'd304;
      4'd12:   n = 9'd334;
      default: n = 9'd0;
    endcase
    if (leap && m > 4'd2) begin
      n = n + 9'd1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- sv/isod_year_base.sv -----
`default_nettype none

// Day number of January 1 of the year +/-(100*hi + lo), and its leap flag.
module isod_year_base (
  input  wire logic [6:0]  hi,
  input  wire logic [6:0]  lo,
  input  wire logic        neg,
  output logic      [22:0] year_base,
  output logic             leap
);

  logic [23:0] mag365;
  logic [6:0]  zhi;
  logic [6:0]  zlo;
  logic        nz;
  logic [23:0] leaps;
  logic [23:0] total;

  always_comb begin
    mag365 = 24'(hi) * 24'd36500 + 24'(lo) * 24'd365;
    if (!neg) begin
      zhi = 7'(hi + 7'd12);
      zlo = lo;
    end else if (lo == 7'd0) begin
      zhi = 7'(7'd12 - hi);
      zlo = 7'd0;
    end else begin
      zhi = 7'(7'd11 - hi);
      zlo = 7'(7'd100 - lo);
    end
    nz = (zlo != 7'd0);
    // leap years in [-1200, year-1]: z/4 - z/100 + z/400 with ceilings, z = year + 1200
    leaps = 24'(zhi) * 24'd25 + 24'((zlo + 7'd3) >> 2) - 24'(zhi) - 24'(nz)
          + 24'((8'(zhi) + 8'(nz) + 8'd3) >> 2);
    total = (neg ? (24'd0 - mag365) : mag365) + leaps - isod_pkg::YEAR_BIAS;
    year_base = total[22:0];
    leap = (lo[1:0] == 2'd0) && ((lo != 7'd0) || (hi[1:0] == 2'd0));
  end

endmodule

`default_nettype wire

// ----- sv/isod_char_parse.sv -----
`default_nettype none

module isod_char_parse (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           take,
  input  wire logic [7:0]     symbol,
  input  wire logic           last_symbol,
  output isod_pkg::parse_t    view
);

  logic [3:0]  position, position_next;
  logic [6:0]  year_hi, year_hi_next;
  logic [6:0]  year_lo, year_lo_next;
  logic [6:0]  month_value, month_value_next;
  logic [6:0]  day_value, day_value_next;
  logic [2:0]  sign_flags, sign_flags_next;
  logic [2:0]  field_bad, field_bad_next;
  logic        format_bad, format_bad_next;
  logic [22:0] year_base;
  logic        year_leap;

  logic        is_digit;
  logic        is_sep;
  logic [6:0]  acc_src;
  logic [6:0]  acc_val;
  logic [22:0] yb_calc;
  logic        leap_calc;

  isod_year_base u_year (
    .hi        (year_hi),
    .lo        (year_lo),
    .neg       (sign_flags[isod_pkg::FLD_YEAR]),
    .year_base (yb_calc),
    .leap      (leap_calc)
  );

  always_comb begin
    is_digit = (symbol >= isod_pkg::DIGIT_LO) && (symbol <= isod_pkg::DIGIT_HI);
    is_sep   = (symbol == isod_pkg::SEP_CHAR);

    case (position) inside
      isod_pkg::POS_Y0, isod_pkg::POS_Y1: acc_src = year_hi;
      isod_pkg::POS_Y2, isod_pkg::POS_Y3: acc_src = year_lo;
      isod_pkg::POS_M0, isod_pkg::POS_M1: acc_src = month_value;
      default:                            acc_src = day_value;
    endcase
    acc_val = isod_pkg::acc10(acc_src, symbol[3:0]);

    year_hi_next     = year_hi;
    year_lo_next     = year_lo;
    month_value_next = month_value;
    day_value_next   = day_value;
    sign_flags_next  = sign_flags;
    field_bad_next   = field_bad;
    format_bad_next  = format_bad;

    case (position) inside
      isod_pkg::POS_Y0, isod_pkg::POS_Y1: begin
        if (is_digit) begin
          year_hi_next = acc_val;
        end else if (position == isod_pkg::POS_Y0 && is_sep) begin
          sign_flags_next[isod_pkg::FLD_YEAR] = 1'b1;
        end else begin
          field_bad_next[isod_pkg::FLD_YEAR] = 1'b1;
        end
      end
      isod_pkg::POS_Y2, isod_pkg::POS_Y3: begin
        if (is_digit) begin
          year_lo_next = acc_val;
        end else begin
          field_bad_next[isod_pkg::FLD_YEAR] = 1'b1;
        end
      end
      isod_pkg::POS_S1, isod_pkg::POS_S2: begin
        if (!is_sep) begin
          format_bad_next = 1'b1;
        end
      end
      isod_pkg::POS_M0, isod_pkg::POS_M1: begin
        if (is_digit) begin
          month_value_next = acc_val;
        end else if (position == isod_pkg::POS_M0 && is_sep) begin
          sign_flags_next[isod_pkg::FLD_MONTH] = 1'b1;
        end else begin
          field_bad_next[isod_pkg::FLD_MONTH] = 1'b1;
        end
      end
      isod_pkg::POS_D0, isod_pkg::POS_D1: begin
        if (is_digit) begin
          day_value_next = acc_val;
        end else if (position == isod_pkg::POS_D0 && is_sep) begin
          sign_flags_next[isod_pkg::FLD_DAY] = 1'b1;
        end else begin
          field_bad_next[isod_pkg::FLD_DAY] = 1'b1;
        end
      end
      default: begin
      end
    endcase

    position_next = (position < isod_pkg::POS_SAT) ? 4'(position + 4'd1) : position;

    view.idx       = position;
    view.fmt_bad   = format_bad_next;
    view.bad       = field_bad_next;
    view.sign      = sign_flags_next;
    view.month     = month_value_next;
    view.day       = day_value_next;
    view.year_base = year_base;
    view.leap      = year_leap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position    <= '0;
      year_hi     <= '0;
      year_lo     <= '0;
      month_value <= '0;
      day_value   <= '0;
      sign_flags  <= '0;
      field_bad   <= '0;
      format_bad  <= 1'b0;
    end else if (take) begin
      if (last_symbol) begin
        position    <= '0;
        year_hi     <= '0;
        year_lo     <= '0;
        month_value <= '0;
        day_value   <= '0;
        sign_flags  <= '0;
        field_bad   <= '0;
        format_bad  <= 1'b0;
      end else begin
        position    <= position_next;
        year_hi     <= year_hi_next;
        year_lo     <= year_lo_next;
        month_value <= month_value_next;
        day_value   <= day_value_next;
        sign_flags  <= sign_flags_next;
        field_bad   <= field_bad_next;
        format_bad  <= format_bad_next;
      end
    end
  end

  // year digits are complete when the first separator arrives
  always_ff @(posedge clk) begin
    if (take && position == isod_pkg::POS_S1) begin
      year_base <= yb_calc;
      year_leap <= leap_calc;
    end
  end

endmodule

`default_nettype wire

// ----- sv/isod_date_check.sv -----
`default_nettype none

module isod_date_check (
  input  wire isod_pkg::parse_t  view,
  output isod_pkg::result_t      res
);

  logic        cal_bad;
  logic [4:0]  mlen;
  logic [8:0]  prior_days;

  always_comb begin
    mlen       = isod_pkg::month_len(view.month[3:0], view.leap);
    prior_days = isod_pkg::days_before_month(view.month[3:0], view.leap);
    cal_bad = view.sign[isod_pkg::FLD_MONTH] || view.sign[isod_pkg::FLD_DAY]
           || (view.month < 7'd1) || (view.month > 7'd12)
           || (view.day < 7'd1) || (view.day > 7'(mlen));
    res.days = '0;
    if (view.idx != isod_pkg::POS_D1 || view.fmt_bad) begin
      res.status = isod_pkg::ST_FMT;
    end else if (view.bad[isod_pkg::FLD_YEAR]) begin
      res.status = isod_pkg::ST_YEAR;
    end else if (view.bad[isod_pkg::FLD_MONTH]) begin
      res.status = isod_pkg::ST_MONTH;
    end else if (view.bad[isod_pkg::FLD_DAY]) begin
      res.status = isod_pkg::ST_DAY;
    end else if (cal_bad) begin
      res.status = isod_pkg::ST_CAL;
    end else begin
      res.status = isod_pkg::ST_OK;
      res.days   = view.year_base + 23'(prior_days) + 23'(view.day) - 23'd1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/isod_out_buf.sv -----
`default_nettype none

// result register with one skid entry
module isod_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire isod_pkg::result_t   din,
  output logic                     room,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output isod_pkg::result_t        dout
);

  logic              skid_valid;
  isod_pkg::result_t skid;

  assign room = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      dout <= skid_valid ? skid : din;
    end else if (push) begin
      skid <= din;
    end
  end

  a_skid_has_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid entry without head entry");

  a_err_zero_days: assert property (@(posedge clk) disable iff (rst)
    out_valid && (dout.status != isod_pkg::ST_OK) |-> dout.days == '0)
    else $error("nonzero day count with error status");

  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready && !skid_valid && push |=> skid_valid)
    else $error("stalled transfer lost");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> dout.status <= isod_pkg::ST_CAL) else $error("status out of range");

endmodule

`default_nettype wire

// ----- sv/iso_date_text_to_day_number_unit.sv -----
// Output: the result is registered when the last character is transferred.
// Throughput: one character per cycle while in_ready; results at up to one per cycle.
// A result register plus one skid entry keep input flowing while one result stalls.
// Reset: rst is synchronous, active high, clears the parse state and the output buffer.
`default_nettype none

module iso_date_text_to_day_number_unit (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         symbol,
  input  wire logic               last_symbol,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [22:0]      day_number,
  output logic        [2:0]       status
);

  logic              take;
  isod_pkg::parse_t  view;
  isod_pkg::result_t res;
  isod_pkg::result_t dout;

  assign take = in_valid && in_ready;

  isod_char_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .symbol      (symbol),
    .last_symbol (last_symbol),
    .view        (view)
  );

  isod_date_check u_check (
    .view (view),
    .res  (res)
  );

  isod_out_buf u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (take && last_symbol),
    .din       (res),
    .room      (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dout      (dout)
  );

  assign day_number = $signed(dout.days);
  assign status     = dout.status;

endmodule

`default_nettype wire
